[hdl/cmba_pkg.sv]
// ----------------------------------------------------------------------------
// cmba_pkg
// types and constants shared by the bit model arithmetic encoder modules
// ----------------------------------------------------------------------------
package cmba_pkg;

  localparam logic CMD_CODE  = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam int unsigned SSE_ROW   = 17;
  localparam logic [13:0] SSE_PLANE = 14'd4352;
  localparam logic [15:0] CNT_INIT  = 16'h8000;

  localparam logic [1:0] RATE_O0  = 2'd2;
  localparam logic [2:0] RATE_O1  = 3'd4;
  localparam logic [2:0] RATE_SSE = 3'd6;

  typedef struct packed {
    logic       cmd;
    logic [7:0] symbol;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MIX,
    ST_SSE_RD,
    ST_INTERP,
    ST_PREP,
    ST_MUL,
    ST_NARROW,
    ST_WR2,
    ST_RENORM,
    ST_FLUSH,
    ST_FINISH
  } state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CLEAR,
    DP_START,
    DP_READ,
    DP_MIX,
    DP_SSE_RD,
    DP_INTERP,
    DP_PREP,
    DP_MUL,
    DP_NARROW,
    DP_WR2,
    DP_EMIT,
    DP_NEXT_BIT,
    DP_FLUSH_EMIT,
    DP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic renorm_need;
    logic can_emit;
    logic out_free;
    logic pend_valid;
    logic last_bit;
    logic flush_last;
  } dp_stat_t;

  // counter adaptation toward the coded bit
  function automatic logic [15:0] adapt(input logic [15:0] c, input logic bit_i,
                                        input logic [2:0] rate);
    logic [15:0] r;
    if (bit_i) begin
      r = c + ((~c) >> rate);
    end else begin
      r = c - (c >> rate);
    end
    return r;
  endfunction

endpackage

[hdl/cmba_ctrl.sv]
// ----------------------------------------------------------------------------
// cmba_ctrl
// sequencer for clearing, per-bit coding steps, renormalization and flush
// ----------------------------------------------------------------------------
module cmba_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_cmd,
  output logic               in_ready,
  input  cmba_pkg::dp_stat_t stat,
  output cmba_pkg::dp_cmd_t  cmd,
  output cmba_pkg::state_t   state
);
  import cmba_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (stat.clear_done) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) state_nxt = (in_cmd == CMD_FLUSH) ? ST_FLUSH : ST_READ;
      end
      ST_READ:   state_nxt = ST_MIX;
      ST_MIX:    state_nxt = ST_SSE_RD;
      ST_SSE_RD: state_nxt = ST_INTERP;
      ST_INTERP: state_nxt = ST_PREP;
      ST_PREP:   state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_NARROW;
      ST_NARROW: state_nxt = ST_WR2;
      ST_WR2:    state_nxt = ST_RENORM;
      ST_RENORM: begin
        if (!stat.renorm_need) state_nxt = stat.last_bit ? ST_FINISH : ST_READ;
      end
      ST_FLUSH: begin
        if (stat.can_emit && stat.flush_last) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!stat.pend_valid || stat.out_free) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd.op   = DP_NOP;
    in_ready = 1'b0;
    unique case (state_r)
      ST_CLEAR:  cmd.op = DP_CLEAR;
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = DP_START;
      end
      ST_READ:   cmd.op = DP_READ;
      ST_MIX:    cmd.op = DP_MIX;
      ST_SSE_RD: cmd.op = DP_SSE_RD;
      ST_INTERP: cmd.op = DP_INTERP;
      ST_PREP:   cmd.op = DP_PREP;
      ST_MUL:    cmd.op = DP_MUL;
      ST_NARROW: cmd.op = DP_NARROW;
      ST_WR2:    cmd.op = DP_WR2;
      ST_RENORM: begin
        if (!stat.renorm_need) begin
          cmd.op = DP_NEXT_BIT;
        end else if (stat.can_emit) begin
          cmd.op = DP_EMIT;
        end
      end
      ST_FLUSH:  if (stat.can_emit) cmd.op = DP_FLUSH_EMIT;
      ST_FINISH: if (!stat.pend_valid || stat.out_free) cmd.op = DP_FINISH;
      default:   cmd.op = DP_NOP;
    endcase
  end

  assign state = state_r;

endmodule

[hdl/cmba_dp.sv]
// ----------------------------------------------------------------------------
// cmba_dp
// counter memories, probability mixing, sse, range coder and output stage
// ----------------------------------------------------------------------------
module cmba_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  cmba_pkg::dp_cmd_t   cmd,
  input  cmba_pkg::in_item_t  in_payload,
  output cmba_pkg::dp_stat_t  stat,
  output logic                out_valid,
  input  logic                out_ready,
  output cmba_pkg::out_item_t out_payload
);
  import cmba_pkg::*;

  // memories
  logic [15:0] o0_mem  [256];
  logic [15:0] o1_mem  [65536];
  logic [15:0] sse_mem [8704];
  logic [255:0] o0_vld_r;

  // control registers
  logic [15:0] clr_cnt_r;
  logic [4:0]  clr_k_r;
  logic        cmd_r;
  logic [7:0]  sym_r;
  logic [7:0]  ctx_r;
  logic [2:0]  bitcnt_r;
  logic [7:0]  prev_r;
  logic [7:0]  prev2_r;
  logic [1:0]  run_r;
  logic        flag_r;
  logic [31:0] low_r;
  logic [31:0] high_r;
  logic        pend_valid_r;
  logic [7:0]  pend_byte_r;
  logic        out_valid_r;
  out_item_t   out_r;

  // payload registers
  logic [15:0] p0_q, p1_q, p2_q;
  logic        p0v_q;
  logic [15:0] p_r;
  logic [13:0] s_r;
  logic [15:0] x1_q, x2_q;
  logic signed [29:0] d_r;
  logic [31:0] span_r;
  logic [31:0] mult_r;
  logic [63:0] prod_r;

  logic        bit_c;
  logic [15:0] p0_eff;
  logic [18:0] mix_sum;
  logic [13:0] s_c;
  logic signed [16:0] diff_c;
  logic signed [12:0] frac_c;
  logic signed [17:0] adj_c;
  logic signed [18:0] sse_c;
  logic [16:0] sse17;
  logic [18:0] pr_c;
  logic [31:0] mid_c;
  logic [1:0]  run_c;
  logic        out_free;
  logic        push;

  assign bit_c   = sym_r[7];
  assign p0_eff  = p0v_q ? p0_q : CNT_INIT;
  assign mix_sum = {1'b0, p0_eff, 2'b0}
                 + {2'b0, p1_q, 1'b0} + {3'b0, p1_q} + {3'b0, p2_q};
  assign s_c     = (flag_r ? SSE_PLANE : 14'd0) + {2'b0, ctx_r, 4'b0}
                 + {6'b0, ctx_r} + {10'b0, mix_sum[18:15]};
  assign diff_c  = $signed({1'b0, x2_q}) - $signed({1'b0, x1_q});
  assign frac_c  = $signed({1'b0, p_r[11:0]});
  assign adj_c   = d_r[29:12];
  assign sse_c   = $signed({3'b0, x1_q}) + $signed({adj_c[17], adj_c});
  assign sse17   = sse_c[16:0];
  assign pr_c    = {3'b0, p_r} + {2'b0, sse17} + {1'b0, sse17, 1'b0};
  assign mid_c   = low_r + prod_r[63:32];
  assign run_c   = (prev_r == prev2_r) ? ((run_r == 2'd3) ? run_r : run_r + 2'd1) : 2'd0;

  assign out_free = !out_valid_r || out_ready;
  assign push     = ((cmd.op == DP_EMIT) || (cmd.op == DP_FLUSH_EMIT)
                     || (cmd.op == DP_FINISH)) && pend_valid_r;

  // memory ports
  always_ff @(posedge clk) begin
    if (cmd.op == DP_READ) begin
      p0_q <= o0_mem[ctx_r];
      p1_q <= o1_mem[{prev_r, ctx_r}];
      p2_q <= o1_mem[{prev2_r, ctx_r}];
    end
    if (cmd.op == DP_SSE_RD) begin
      x1_q <= sse_mem[s_r];
      x2_q <= sse_mem[s_r + 14'd1];
    end
    if (cmd.op == DP_NARROW) begin
      o0_mem[ctx_r] <= adapt(p0_eff, bit_c, {1'b0, RATE_O0});
    end
    if (cmd.op == DP_CLEAR) begin
      o1_mem[clr_cnt_r] <= CNT_INIT;
    end else if (cmd.op == DP_NARROW) begin
      o1_mem[{prev_r, ctx_r}] <= adapt(p1_q, bit_c, RATE_O1);
    end
    if (cmd.op == DP_CLEAR && clr_cnt_r < 16'd8704) begin
      sse_mem[clr_cnt_r[13:0]] <= {(clr_k_r == 5'd16) ? 4'd15 : clr_k_r[3:0], 12'b0};
    end else if (cmd.op == DP_NARROW) begin
      sse_mem[s_r] <= adapt(x1_q, bit_c, RATE_SSE);
    end else if (cmd.op == DP_WR2) begin
      sse_mem[s_r + 14'd1] <= adapt(x2_q, bit_c, RATE_SSE);
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_READ:   p0v_q  <= o0_vld_r[ctx_r];
      DP_MIX: begin
        p_r <= mix_sum[18:3];
        s_r <= s_c;
      end
      DP_INTERP: d_r    <= diff_c * frac_c;
      DP_PREP: begin
        mult_r <= {pr_c[17:0], 14'b0};
        span_r <= high_r - low_r;
      end
      DP_MUL:    prod_r <= span_r * mult_r;
      default: ;
    endcase
  end

  // control and coder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o0_vld_r     <= '0;
      clr_cnt_r    <= '0;
      clr_k_r      <= '0;
      cmd_r        <= CMD_CODE;
      sym_r        <= '0;
      ctx_r        <= 8'd1;
      bitcnt_r     <= '0;
      prev_r       <= '0;
      prev2_r      <= '0;
      run_r        <= '0;
      flag_r       <= 1'b0;
      low_r        <= '0;
      high_r       <= '1;
      pend_valid_r <= 1'b0;
      pend_byte_r  <= '0;
      out_valid_r  <= 1'b0;
      out_r        <= '0;
    end else begin
      if (push) begin
        out_valid_r <= 1'b1;
        out_r       <= '{out_byte: pend_byte_r, last: (cmd.op == DP_FINISH)};
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        DP_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 16'd1;
          clr_k_r   <= (clr_k_r == 5'd16) ? 5'd0 : clr_k_r + 5'd1;
        end
        DP_START: begin
          cmd_r    <= in_payload.cmd;
          sym_r    <= in_payload.symbol;
          ctx_r    <= 8'd1;
          bitcnt_r <= '0;
          if (in_payload.cmd == CMD_CODE) begin
            run_r  <= run_c;
            flag_r <= (run_c == 2'd3);
          end
        end
        DP_NARROW: begin
          o0_vld_r[ctx_r] <= 1'b1;
          if (bit_c) begin
            high_r <= mid_c;
          end else begin
            low_r <= mid_c + 32'd1;
          end
        end
        DP_EMIT: begin
          pend_valid_r <= 1'b1;
          pend_byte_r  <= low_r[31:24];
          low_r        <= {low_r[23:0], 8'h00};
          high_r       <= {high_r[23:0], 8'hff};
        end
        DP_FLUSH_EMIT: begin
          pend_valid_r <= 1'b1;
          pend_byte_r  <= low_r[31:24];
          low_r        <= {low_r[23:0], 8'h00};
          bitcnt_r     <= bitcnt_r + 3'd1;
        end
        DP_NEXT_BIT: begin
          ctx_r    <= {ctx_r[6:0], bit_c};
          sym_r    <= {sym_r[6:0], 1'b0};
          bitcnt_r <= bitcnt_r + 3'd1;
        end
        DP_FINISH: begin
          // the held byte leaves now as the final one
          pend_valid_r <= 1'b0;
          if (cmd_r == CMD_CODE) begin
            prev2_r <= prev_r;
            prev_r  <= ctx_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign stat.clear_done  = (clr_cnt_r == 16'hffff);
  assign stat.renorm_need = ((low_r ^ high_r) >> 24) == 32'd0;
  assign stat.can_emit    = !pend_valid_r || out_free;
  assign stat.out_free    = out_free;
  assign stat.pend_valid  = pend_valid_r;
  assign stat.last_bit    = (bitcnt_r == 3'd7);
  assign stat.flush_last  = (bitcnt_r == 3'd3);

  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

endmodule

[hdl/cm_bit_model_arith_encoder.sv]
// ----------------------------------------------------------------------------
// cm_bit_model_arith_encoder
// context mixing binary arithmetic encoder with secondary estimation
// ----------------------------------------------------------------------------
// Each request either codes one symbol byte, most significant bit first, or
// flushes the four bytes of the range coder's low word. After reset the block
// runs a clearing pass over the counter memories and takes no request until
// it ends. A code request takes an accept step, then per bit the steps memory
// read, mix, sse read, interpolation multiply, range setup, range multiply,
// narrow, second sse write and renorm check, an emit step per emitted byte,
// and a closing step. A flush takes an accept step, an emit step per byte
// and a closing step. Output stalls hold the emit and closing steps. Each
// emitted byte is one result request; the final byte caused by a request
// carries last. A request that emits nothing gives no result.
module cm_bit_model_arith_encoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cmba_pkg::in_item_t  in_payload,
  output logic                out_valid,
  input  logic                out_ready,
  output cmba_pkg::out_item_t out_payload
);
  import cmba_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  state_t   state;

  // sequencer
  cmba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_payload.cmd),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd),
    .state    (state)
  );

  // memories, arithmetic and output register
  cmba_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_payload  (in_payload),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_payload (out_payload)
  );

  // no request is taken during the clearing pass
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state == ST_CLEAR) |-> !in_ready)
    else $error("request taken while clearing");

  // a pending byte is never left behind when going idle
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state == ST_IDLE) |-> !stat.pend_valid)
    else $error("pending byte stranded");

  // a byte is only produced when it has somewhere to go
  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == DP_EMIT || cmd.op == DP_FLUSH_EMIT) |-> stat.can_emit)
    else $error("emit without room");

endmodule
